// ===== design/scc_pkg.sv =====
`timescale 1ns / 1ps
package scc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_TEMP    = 3'd0;
  localparam logic [2:0] CFG_PRESS_A = 3'd1;
  localparam logic [2:0] CFG_PRESS_B = 3'd2;
  localparam logic [2:0] CFG_PRESS_9 = 3'd3;
  localparam logic [2:0] CFG_HUM_A   = 3'd4;
  localparam logic [2:0] CFG_HUM_B   = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 88;

  // pressure divider: one quotient bit per stage, plus sign-in and sign-out stages
  localparam int DIV_W   = 64;
  localparam int DIV_LAT = DIV_W + 2;

  localparam logic [63:0] P_T_OFFSET   = 64'd128000;
  localparam logic [63:0] P_ADC_FULL   = 64'd1048576;
  localparam logic [63:0] P_SCALE      = 64'd3125;
  localparam logic [63:0] P_P1_BIAS    = 64'h0000_8000_0000_0000;
  localparam logic [31:0] H_T_OFFSET   = 32'd76800;
  localparam logic [31:0] H_X_ROUND    = 32'd16384;
  localparam logic [31:0] H_W_BIAS     = 32'd2097152;
  localparam logic [31:0] H_Z_BIAS     = 32'd32768;
  localparam logic [31:0] H_E_ROUND    = 32'd8192;
  localparam logic [31:0] H_MAX        = 32'd419430400;
  localparam logic [31:0] T_ROUND      = 32'd128;

  function automatic logic [63:0] sx16_64(input logic [15:0] v);
    sx16_64 = {{48{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx16_32(input logic [15:0] v);
    sx16_32 = {{16{v[15]}}, v};
  endfunction

endpackage

// ===== design/sensor_calibration_compensation.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Signals                               Word
// in_       in   in_tvalid/in_tready/in_tdata[55:0]    one raw record
// out_      out  out_tvalid/out_tready/out_tdata/tuser one compensated record
// cfg_      in   cfg_we/cfg_index/cfg_wdata[63:0]      one coefficient register
//
// One record enters per cycle while out_tready lets the pipeline move. Its word
// shows on out_tvalid after 87 register stages, 66 of them in the pressure divider
// (one quotient bit per stage plus a sign-in and a sign-out stage).
// rst_n is synchronous; it clears valid bits and coefficient registers.
// The whole pipeline holds while the output word waits; nothing is dropped.
module sensor_calibration_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [19:0] adc_pressure, [39:20] adc_temperature, [55:40] adc_humidity
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] temperature_centi, [63:32] pressure_q24_8, [80:64] humidity_q22_10
  output logic [87:0] out_tdata,
  // [0] pressure_divisor_zero
  output logic [0:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int K_DIV_IN = 15;
  localparam int K_QUO    = K_DIV_IN + scc_pkg::DIV_LAT;
  localparam int K_SUM    = K_QUO + 5;
  localparam int LAT      = K_SUM + 1;

  // ---------------- coefficient registers
  logic [47:0] temp_c_r;
  logic [63:0] press_a_r;
  logic [63:0] press_b_r;
  logic [15:0] press_9_r;
  logic [31:0] hum_a_r;
  logic [39:0] hum_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_c_r  <= '0;
      press_a_r <= '0;
      press_b_r <= '0;
      press_9_r <= '0;
      hum_a_r   <= '0;
      hum_b_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        scc_pkg::CFG_TEMP:    temp_c_r  <= cfg_wdata[47:0];
        scc_pkg::CFG_PRESS_A: press_a_r <= cfg_wdata;
        scc_pkg::CFG_PRESS_B: press_b_r <= cfg_wdata;
        scc_pkg::CFG_PRESS_9: press_9_r <= cfg_wdata[15:0];
        scc_pkg::CFG_HUM_A:   hum_a_r   <= cfg_wdata[31:0];
        scc_pkg::CFG_HUM_B:   hum_b_r   <= cfg_wdata[39:0];
        default: ;
      endcase
    end
  end

  // unpack coefficients to the width of their path: t1, p1, h1, h3 zero-extended, the rest sign-extended
  logic [31:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {16'b0, temp_c_r[15:0]};
  assign t2 = scc_pkg::sx16_32(temp_c_r[31:16]);
  assign t3 = scc_pkg::sx16_32(temp_c_r[47:32]);
  assign p1 = {48'b0, press_a_r[15:0]};
  assign p2 = scc_pkg::sx16_64(press_a_r[31:16]);
  assign p3 = scc_pkg::sx16_64(press_a_r[47:32]);
  assign p4 = scc_pkg::sx16_64(press_a_r[63:48]);
  assign p5 = scc_pkg::sx16_64(press_b_r[15:0]);
  assign p6 = scc_pkg::sx16_64(press_b_r[31:16]);
  assign p7 = scc_pkg::sx16_64(press_b_r[47:32]);
  assign p8 = scc_pkg::sx16_64(press_b_r[63:48]);
  assign p9 = scc_pkg::sx16_64(press_9_r);
  assign h1 = {24'b0, hum_a_r[7:0]};
  assign h2 = scc_pkg::sx16_32(hum_a_r[23:8]);
  assign h3 = {24'b0, hum_a_r[31:24]};
  assign h4 = scc_pkg::sx16_32(hum_b_r[15:0]);
  assign h5 = scc_pkg::sx16_32(hum_b_r[31:16]);
  assign h6 = {{24{hum_b_r[39]}}, hum_b_r[39:32]};

  // ---------------- flow control: one enable for every stage
  logic           pipe_en;
  logic [LAT-1:0] vld_r;

  assign pipe_en   = !vld_r[LAT-1] || out_tready;
  assign in_tready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  logic [19:0] adc_p, adc_t;
  logic [15:0] adc_h;
  assign adc_p = in_tdata[19:0];
  assign adc_t = in_tdata[39:20];
  assign adc_h = in_tdata[55:40];

  // ---------------- temperature, 32-bit wrapping (stages 1..6)
  logic [31:0] d1_r, d2_r, m1_r, m2_r, v1_r, q_r, v1b_r, m3_r, tfine_r;
  logic [31:0] temp_r, hv_r;
  logic [63:0] pa_r;
  logic [31:0] tf5;

  assign tf5 = {tfine_r[29:0], 2'b0} + tfine_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      d1_r    <= {15'b0, adc_t[19:3]} - {t1[30:0], 1'b0};
      d2_r    <= {16'b0, adc_t[19:4]} - t1;
      m1_r    <= d1_r * t2;
      m2_r    <= d2_r * d2_r;
      v1_r    <= 32'($signed(m1_r) >>> 11);
      q_r     <= 32'($signed(m2_r) >>> 12);
      v1b_r   <= v1_r;
      m3_r    <= q_r * t3;
      tfine_r <= v1b_r + 32'($signed(m3_r) >>> 14);
      temp_r  <= 32'($signed(tf5 + scc_pkg::T_ROUND) >>> 8);
      pa_r    <= {{32{tfine_r[31]}}, tfine_r} - scc_pkg::P_T_OFFSET;
      hv_r    <= tfine_r - scc_pkg::H_T_OFFSET;
    end
  end

  // ---------------- humidity, 32-bit wrapping (stages 7..15)
  logic [15:0] adch_d;
  logic [31:0] mh5v_r, mvh6_r, mvh3_r, hx_r, hy_r, hz_r, yz_r, wh2_r, he_r;
  logic [31:0] hxd, xe_r, xed, ss_r, sh_r, hsub, hs;
  logic [16:0] hum_r;
  logic [31:0] hx_nxt;

  scc_delay #(.W(16), .N(7)) u_dly_adch (
    .clk(clk), .en(pipe_en), .d(adc_h), .q(adch_d)
  );

  assign hx_nxt = ({16'b0, adch_d} << 14) - ((h4 << 20) + mh5v_r) + scc_pkg::H_X_ROUND;
  assign hs     = 32'($signed(xe_r) >>> 15);
  assign hsub   = xed - 32'($signed(sh_r) >>> 4);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      mh5v_r <= h5 * hv_r;
      mvh6_r <= hv_r * h6;
      mvh3_r <= hv_r * h3;
      hx_r   <= 32'($signed(hx_nxt) >>> 15);
      hy_r   <= 32'($signed(mvh6_r) >>> 10);
      hz_r   <= 32'($signed(mvh3_r) >>> 11) + scc_pkg::H_Z_BIAS;
      yz_r   <= hy_r * hz_r;
      wh2_r  <= (32'($signed(yz_r) >>> 10) + scc_pkg::H_W_BIAS) * h2;
      he_r   <= 32'($signed(wh2_r + scc_pkg::H_E_ROUND) >>> 14);
      xe_r   <= hxd * he_r;
      ss_r   <= hs * hs;
      sh_r   <= 32'($signed(ss_r) >>> 7) * h1;
      // clamp to the legal range, then drop the 12 fraction bits
      if (hsub[31]) begin
        hum_r <= '0;
      end else if (hsub > scc_pkg::H_MAX) begin
        hum_r <= scc_pkg::H_MAX[28:12];
      end else begin
        hum_r <= hsub[28:12];
      end
    end
  end

  scc_delay #(.W(32), .N(3)) u_dly_hx (
    .clk(clk), .en(pipe_en), .d(hx_r), .q(hxd)
  );
  scc_delay #(.W(32), .N(2)) u_dly_xe (
    .clk(clk), .en(pipe_en), .d(xe_r), .q(xed)
  );

  // ---------------- pressure, 64-bit wrapping
  logic [63:0] aa, ap5, ap2, ap5d, ap2d, aap6, aap3;
  logic [63:0] b_r, a2_r, pre_r, nump_r, xmul, num, den_r, num_r;
  logic [19:0] adcp_d;
  logic [63:0] praw;

  scc_mul64 u_aa  (.clk(clk), .en(pipe_en), .a(pa_r), .b(pa_r), .p(aa));
  scc_mul64 u_ap5 (.clk(clk), .en(pipe_en), .a(pa_r), .b(p5),   .p(ap5));
  scc_mul64 u_ap2 (.clk(clk), .en(pipe_en), .a(pa_r), .b(p2),   .p(ap2));

  scc_delay #(.W(128), .N(2)) u_dly_ap (
    .clk(clk), .en(pipe_en), .d({ap5, ap2}), .q({ap5d, ap2d})
  );

  scc_mul64 u_aap6 (.clk(clk), .en(pipe_en), .a(aa), .b(p6), .p(aap6));
  scc_mul64 u_aap3 (.clk(clk), .en(pipe_en), .a(aa), .b(p3), .p(aap3));

  scc_delay #(.W(20), .N(11)) u_dly_adcp (
    .clk(clk), .en(pipe_en), .d(adc_p), .q(adcp_d)
  );

  assign praw = scc_pkg::P_ADC_FULL - {44'b0, adcp_d};

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      b_r    <= aap6 + (ap5d << 17) + (p4 << 35);
      a2_r   <= 64'($signed(aap3) >>> 8) + (ap2d << 12);
      pre_r  <= scc_pkg::P_P1_BIAS + a2_r;
      nump_r <= (praw << 31) - b_r;
    end
  end

  scc_mul64 u_xmul (.clk(clk), .en(pipe_en), .a(pre_r),  .b(p1),               .p(xmul));
  scc_mul64 u_num  (.clk(clk), .en(pipe_en), .a(nump_r), .b(scc_pkg::P_SCALE), .p(num));

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      den_r <= 64'($signed(xmul) >>> 33);
      num_r <= num;
    end
  end

  logic [63:0] quo, ps, p8p, pss, c1raw, c2, c2d, pd, sum_r;
  logic        dzero, dzero_d;

  scc_div64 u_div (
    .clk(clk), .en(pipe_en), .num(num_r), .den(den_r), .quo(quo), .zero(dzero)
  );

  assign ps = 64'($signed(quo) >>> 13);

  scc_mul64 u_p8p (.clk(clk), .en(pipe_en), .a(quo), .b(p8), .p(p8p));
  scc_mul64 u_pss (.clk(clk), .en(pipe_en), .a(ps),  .b(ps), .p(pss));
  scc_mul64 u_c1  (.clk(clk), .en(pipe_en), .a(pss), .b(p9), .p(c1raw));

  assign c2 = 64'($signed(p8p) >>> 19);

  scc_delay #(.W(64), .N(2)) u_dly_c2 (
    .clk(clk), .en(pipe_en), .d(c2), .q(c2d)
  );
  scc_delay #(.W(64), .N(4)) u_dly_p (
    .clk(clk), .en(pipe_en), .d(quo), .q(pd)
  );
  scc_delay #(.W(1), .N(K_SUM - K_QUO)) u_dly_zero (
    .clk(clk), .en(pipe_en), .d(dzero), .q(dzero_d)
  );

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sum_r <= pd + 64'($signed(c1raw) >>> 25) + c2d;
    end
  end

  // ---------------- align temperature and humidity with pressure
  logic [31:0] temp_d;
  logic [16:0] hum_d;

  scc_delay #(.W(32), .N(K_SUM - 6)) u_dly_temp (
    .clk(clk), .en(pipe_en), .d(temp_r), .q(temp_d)
  );
  scc_delay #(.W(17), .N(K_SUM - K_DIV_IN)) u_dly_hum (
    .clk(clk), .en(pipe_en), .d(hum_r), .q(hum_d)
  );

  // ---------------- output register
  logic [63:0] pfin;
  logic [31:0] press_o_r, temp_o_r;
  logic [16:0] hum_o_r;
  logic        zero_o_r;

  assign pfin = 64'($signed(sum_r) >>> 8) + (p7 << 4);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      temp_o_r  <= temp_d;
      hum_o_r   <= hum_d;
      zero_o_r  <= dzero_d;
      press_o_r <= dzero_d ? 32'd0 : pfin[31:0];
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {7'b0, hum_o_r, press_o_r, temp_o_r};
  assign out_tuser  = zero_o_r;

  // ---------------- assertions
  a_zero_press : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[63:32] == 32'd0)
    else $error("pressure not forced to zero on zero divisor");

  a_hum_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[80:64] <= 17'd102400)
    else $error("humidity above clamp");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(vld_r))
    else $error("pipeline moved during stall");

endmodule

// ===== design/scc_delay.sv =====
`timescale 1ns / 1ps
module scc_delay #(
  parameter int W = 32,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [0:N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
    end
  end

  for (genvar i = 1; i < N; i++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule

// ===== design/scc_mul64.sv =====
`timescale 1ns / 1ps
module scc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  // low 64 bits of a*b from three 32x32 partial products
  logic [63:0] ll_r;
  logic [31:0] lh_r;
  logic [31:0] hl_r;
  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= {32'b0, a[31:0]} * {32'b0, b[31:0]};
      lh_r <= a[31:0] * b[63:32];
      hl_r <= a[63:32] * b[31:0];
      p_r  <= ll_r + {lh_r + hl_r, 32'b0};
    end
  end

  assign p = p_r;

endmodule

// ===== design/scc_div64.sv =====
`timescale 1ns / 1ps
module scc_div64 #(
  parameter int W = scc_pkg::DIV_W
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic [W-1:0] quo,
  output logic         zero
);

  // signed division, truncating toward zero, one quotient bit per stage
  logic [W-1:0] rem_r  [0:W];
  logic [W-1:0] nq_r   [0:W];
  logic [W-1:0] dv_r   [0:W];
  logic         neg_r  [0:W];
  logic         zero_r [0:W];
  logic [W-1:0] quo_r;
  logic         zout_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      nq_r[0]   <= num[W-1] ? (~num + 1'b1) : num;
      dv_r[0]   <= den[W-1] ? (~den + 1'b1) : den;
      neg_r[0]  <= num[W-1] ^ den[W-1];
      zero_r[0] <= (den == '0);
    end
  end

  for (genvar i = 1; i <= W; i++) begin : g_step
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;
    assign trial = {rem_r[i-1], nq_r[i-1][W-1]};
    assign diff  = trial - {1'b0, dv_r[i-1]};
    assign ge    = (trial >= {1'b0, dv_r[i-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff[W-1:0] : trial[W-1:0];
        nq_r[i]   <= {nq_r[i-1][W-2:0], ge};
        dv_r[i]   <= dv_r[i-1];
        neg_r[i]  <= neg_r[i-1];
        zero_r[i] <= zero_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r  <= neg_r[W] ? (~nq_r[W] + 1'b1) : nq_r[W];
      zout_r <= zero_r[W];
    end
  end

  assign quo  = quo_r;
  assign zero = zout_r;

endmodule
